[src/wilder_rsi_stream_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Wilder RSI stream block.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WILDER_RSI_STREAM_ASSERT_SVH
`define WILDER_RSI_STREAM_ASSERT_SVH

// Same-cycle implication.
`define WRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wrs_pkg.sv]
// ----------------------------------------------------------------------------
// wrs_pkg
// Widths, constants and sequencer states of the Wilder RSI stream block.
// ----------------------------------------------------------------------------
package wrs_pkg;

	localparam int ACC_W       = 56;          // sums and averages, Q.FRACTION_BITS
	localparam int COUNT_W     = 9;           // series index, saturating
	localparam int PERIOD_W    = 8;           // period register
	localparam int PCAP_W      = 10;          // width that holds any period cap
	localparam int RSI_W       = 14;          // RSI in hundredths of a percent
	localparam int OUT_TDATA_W = 16;          // rsi_value padded to bytes
	localparam int PROD_W      = ACC_W + RSI_W;
	localparam int DIV_R_W     = ACC_W + 1;   // remainder / divisor (gain + loss)
	localparam int DIV_CNT_W   = 6;           // step count, up to ACC_W - 1

	localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 8'd14;
	localparam logic [RSI_W-1:0]     RSI_FULL     = 14'd10000;
	localparam logic [COUNT_W-1:0]   COUNT_MAX    = 9'd511;
	localparam logic [DIV_CNT_W-1:0] AVG_LAST     = DIV_CNT_W'(ACC_W - 1);
	localparam logic [DIV_CNT_W-1:0] RSI_LAST     = DIV_CNT_W'(RSI_W - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_ADD   = 9'b000001000,
		S_LOAD  = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_RMUL  = 9'b001000000,
		S_RLOAD = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

endpackage

[src/wilder_rsi_stream.sv]
// ----------------------------------------------------------------------------
// wilder_rsi_stream
// Streaming Wilder relative strength index over closing prices, with one
// shared multiplier and one shared shift-subtract divider under a sequencer.
// Sequence: a first or warm-up price passes S_PREP and S_OUT; the price
//   that completes the first average divides both sums by the period; a
//   smoothed price multiplies, adds and divides per average; both then
//   divide for the ratio unless either average is zero. A new price waits
//   for S_IDLE. Divider, 1 bit per cycle: 56 steps per average, 14 for the ratio.
// Reset (arst_n low): period returns to 14, series state clears, no output.
// ----------------------------------------------------------------------------
module wilder_rsi_stream #(
	parameter int PRICE_BITS    = 32,   // 8..48
	parameter int FRACTION_BITS = 16,   // 8..24
	parameter int MAX_PERIOD    = 255   // 2..1023
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: smoothing_period
	input  logic                                cfg_wr_en,
	input  logic [wrs_pkg::PERIOD_W-1:0]        cfg_wr_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((PRICE_BITS+7)/8)*8-1:0]     s_tdata,   // close_price
	input  logic                                s_tuser,   // start_series
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wrs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rsi_value
	output logic                                m_tuser    // rsi_valid
);

	import wrs_pkg::*;

	localparam logic [PCAP_W-1:0] PERIOD_CAP = PCAP_W'(MAX_PERIOD);

	// ------------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------------
	state_t                 state_q;
	logic [PERIOD_W-1:0]    period_cfg_q;

	// series state
	logic [PRICE_BITS-1:0]  prev_close_q;
	logic [COUNT_W-1:0]     items_q;
	logic [ACC_W-1:0]       gain_acc_q;
	logic [ACC_W-1:0]       loss_acc_q;

	// captured transaction and its difference
	logic [PRICE_BITS-1:0]  price_q;
	logic                   start_q;
	logic [ACC_W-1:0]       x_gain_q;
	logic [ACC_W-1:0]       x_loss_q;

	// sequencer flags
	logic                   sel_loss_q;   // 0: working on gain, 1: on loss
	logic                   smooth_q;     // Wilder smoothing, not initial average
	logic                   rsi_mode_q;   // divider computing the ratio

	// shared multiplier output
	logic [PROD_W-1:0]      prod_q;

	// shared divider: remainder, dividend/quotient shifter, divisor, step
	logic [DIV_R_W-1:0]     div_rem_q;
	logic [ACC_W-1:0]       div_quo_q;
	logic [DIV_R_W-1:0]     div_den_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	// finished result and output register
	logic [RSI_W-1:0]       res_rsi_q;
	logic                   res_valid_q;
	logic                   m_tvalid_q;
	logic [RSI_W-1:0]       out_rsi_q;
	logic                   out_valid_q;

	// ------------------------------------------------------------------------
	// Effective period: 0 acts as 1, values above the cap act as the cap
	// ------------------------------------------------------------------------
	logic [PCAP_W-1:0]      period_ext;
	logic [PCAP_W-1:0]      period_clip;
	logic [PERIOD_W-1:0]    period;

	always_comb begin
		period_ext  = (period_cfg_q == '0) ? PCAP_W'(1) : PCAP_W'(period_cfg_q);
		period_clip = (period_ext > PERIOD_CAP) ? PERIOD_CAP : period_ext;
		period      = period_clip[PERIOD_W-1:0];   // at most the register value, or 1 when it is 0
	end

	// ------------------------------------------------------------------------
	// Price difference, scaled to Q.FRACTION_BITS
	// ------------------------------------------------------------------------
	logic                   up_move;
	logic [PRICE_BITS-1:0]  move_abs;
	logic [ACC_W-1:0]       move_fx;
	logic [ACC_W-1:0]       gain_x;
	logic [ACC_W-1:0]       loss_x;

	always_comb begin
		up_move  = price_q > prev_close_q;
		move_abs = up_move ? (price_q - prev_close_q) : (prev_close_q - price_q);
		move_fx  = ACC_W'(move_abs) << FRACTION_BITS;
		gain_x   = up_move ? move_fx : '0;
		loss_x   = up_move ? '0 : move_fx;
	end

	// phase of this price: index below, at, or past the period
	logic                   idx_below;
	logic                   idx_equal;
	logic [COUNT_W-1:0]     items_inc;

	assign idx_below = items_q < COUNT_W'(period);
	assign idx_equal = items_q == COUNT_W'(period);
	assign items_inc = (items_q == COUNT_MAX) ? items_q : items_q + COUNT_W'(1);

	// ------------------------------------------------------------------------
	// Shared multiplier: avg * (period - 1) for smoothing, gain * 10000 for RSI
	// ------------------------------------------------------------------------
	logic [ACC_W-1:0]       acc_sel;
	logic [ACC_W-1:0]       x_sel;
	logic [ACC_W-1:0]       mul_a;
	logic [RSI_W-1:0]       mul_b;
	logic [PROD_W-1:0]      prod_d;
	logic [ACC_W-1:0]       smooth_sum;

	always_comb begin
		acc_sel    = sel_loss_q ? loss_acc_q : gain_acc_q;
		x_sel      = sel_loss_q ? x_loss_q : x_gain_q;
		mul_a      = (state_q == S_RMUL) ? gain_acc_q : acc_sel;
		mul_b      = (state_q == S_RMUL) ? RSI_FULL : RSI_W'(period - PERIOD_W'(1));
		prod_d     = PROD_W'(mul_a) * PROD_W'(mul_b);
		smooth_sum = prod_q[ACC_W-1:0] + x_sel;   // wraps modulo 2^56
	end

	// ------------------------------------------------------------------------
	// Shared restoring divider step, one quotient bit per cycle
	// ------------------------------------------------------------------------
	logic [DIV_R_W:0]       div_shift;
	logic                   div_ge;
	logic [DIV_R_W:0]       div_sub;
	logic [DIV_R_W-1:0]     div_rem_d;
	logic [ACC_W-1:0]       div_quo_d;
	logic [DIV_CNT_W-1:0]   div_last;

	always_comb begin
		div_shift = {div_rem_q, div_quo_q[ACC_W-1]};
		div_ge    = div_shift >= {1'b0, div_den_q};
		div_sub   = div_shift - {1'b0, div_den_q};
		div_rem_d = div_ge ? div_sub[DIV_R_W-1:0] : div_shift[DIV_R_W-1:0];
		div_quo_d = {div_quo_q[ACC_W-2:0], div_ge};
		div_last  = rsi_mode_q ? RSI_LAST : AVG_LAST;
	end

	// ------------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------------
	logic in_fire;
	logic out_load;

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	// result moves to the output register once the previous one is taken
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(out_rsi_q);
	assign m_tuser  = out_valid_q;

	// ------------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_cfg_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer and series state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_close_q <= '0;
			items_q      <= '0;
			gain_acc_q   <= '0;
			loss_acc_q   <= '0;
			sel_loss_q   <= 1'b0;
			smooth_q     <= 1'b0;
			rsi_mode_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_PREP;
					end
				end

				S_PREP: begin
					if (start_q || items_q == '0) begin
						// first price of a series: no difference yet
						prev_close_q <= price_q;
						items_q      <= COUNT_W'(1);
						gain_acc_q   <= '0;
						loss_acc_q   <= '0;
						state_q      <= S_OUT;
					end else begin
						prev_close_q <= price_q;
						items_q      <= items_inc;
						sel_loss_q   <= 1'b0;
						if (idx_below || idx_equal) begin
							gain_acc_q <= gain_acc_q + gain_x;
							loss_acc_q <= loss_acc_q + loss_x;
							smooth_q   <= 1'b0;
							// at index == period the sums become averages
							state_q    <= idx_equal ? S_LOAD : S_OUT;
						end else begin
							smooth_q <= 1'b1;
							state_q  <= S_MUL;
						end
					end
				end

				S_MUL: begin
					state_q <= S_ADD;
				end

				S_ADD: begin
					if (sel_loss_q) begin
						loss_acc_q <= smooth_sum;
					end else begin
						gain_acc_q <= smooth_sum;
					end
					state_q <= S_LOAD;
				end

				S_LOAD: begin
					rsi_mode_q <= 1'b0;
					state_q    <= S_DIV;
				end

				S_DIV: begin
					if (div_cnt_q == div_last) begin
						if (rsi_mode_q) begin
							state_q <= S_OUT;
						end else begin
							if (sel_loss_q) begin
								loss_acc_q <= div_quo_d;
								state_q    <= S_RMUL;
							end else begin
								gain_acc_q <= div_quo_d;
								sel_loss_q <= 1'b1;
								state_q    <= smooth_q ? S_MUL : S_LOAD;
							end
						end
					end
				end

				S_RMUL: begin
					// zero loss gives full scale, zero gain gives zero
					if (loss_acc_q == '0 || gain_acc_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RLOAD;
					end
				end

				S_RLOAD: begin
					rsi_mode_q <= 1'b1;
					state_q    <= S_DIV;
				end

				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers (no reset)
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			price_q <= s_tdata[PRICE_BITS-1:0];
			start_q <= s_tuser;
		end

		if (state_q == S_PREP) begin
			x_gain_q    <= gain_x;
			x_loss_q    <= loss_x;
			// result for a price that produces no average yet
			res_rsi_q   <= '0;
			res_valid_q <= 1'b0;
		end

		if (state_q == S_MUL || state_q == S_RMUL) begin
			prod_q <= prod_d;
		end

		// divide the selected accumulator by the period
		if (state_q == S_LOAD) begin
			div_rem_q <= '0;
			div_quo_q <= acc_sel;
			div_den_q <= DIV_R_W'(period);
			div_cnt_q <= '0;
		end

		// 10000 * G / (G + L): the high part of the product is already below
		// the divisor, so only the low RSI_W bits need shifting in
		if (state_q == S_RLOAD) begin
			div_rem_q <= DIV_R_W'(prod_q[PROD_W-1:RSI_W]);
			div_quo_q <= {prod_q[RSI_W-1:0], (ACC_W-RSI_W)'(0)};
			div_den_q <= DIV_R_W'(gain_acc_q) + DIV_R_W'(loss_acc_q);
			div_cnt_q <= '0;
		end

		if (state_q == S_DIV) begin
			div_rem_q <= div_rem_d;
			div_quo_q <= div_quo_d;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (rsi_mode_q && div_cnt_q == div_last) begin
				res_rsi_q   <= div_quo_d[RSI_W-1:0];
				res_valid_q <= 1'b1;
			end
		end

		if (state_q == S_RMUL) begin
			res_valid_q <= 1'b1;
			if (loss_acc_q == '0) begin
				res_rsi_q <= RSI_FULL;
			end else begin
				res_rsi_q <= '0;
			end
		end

		if (out_load) begin
			out_rsi_q   <= res_rsi_q;
			out_valid_q <= res_valid_q;
		end
	end

	// ------------------------------------------------------------------------
	// Output register valid
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`include "wilder_rsi_stream_assert.svh"

	`WRS_ASSERT_NXT(a_accept_starts_prep, in_fire, state_q == S_PREP, "accept did not start work")
	`WRS_ASSERT_IMP(a_div_rem_below_den, state_q == S_DIV, div_rem_q < div_den_q, "divider remainder out of range")
	`WRS_ASSERT_IMP(a_result_in_range, state_q == S_OUT, res_rsi_q <= RSI_FULL, "rsi above full scale")
	`WRS_ASSERT_IMP(a_invalid_is_zero, state_q == S_OUT && !res_valid_q, res_rsi_q == '0, "invalid rsi not zero")

endmodule
